FILE: sv/pdd_pkg.sv
// Shared constants, types and CORDIC step function for the plane dip and dip direction block.
`default_nettype none

package pdd_pkg;

  // Number of CORDIC micro-rotations; the arctangent table covers at most ATAN_ENTRIES.
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // Datapath widths.
  localparam int FIELD_W    = 16;
  localparam int GUARD_BITS = 24;
  localparam int DW         = 44;
  localparam int ANGLE_W    = 32;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 3;

  // Pipeline depth from the input register up to and including the output register.
  localparam int DEPTH = SQRT_STEPS + CORDIC_N + 5;

  // Angle constants in hundredths of a degree; HALF_TURN is in units of 2^-32 of a full turn.
  localparam logic [15:0] TURN_CDEG = 16'd36000;
  localparam logic [15:0] HALF_CDEG = 16'd18000;
  localparam logic [13:0] DIP_MAX   = 14'd9000;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 of a full turn.
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // One vector in flight through a CORDIC pipeline.
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic [ANGLE_W-1:0]   z;
  } cordic_vec_t;

  // One vectoring micro-rotation; k is a constant at every call site.
  function automatic cordic_vec_t cordic_step(input cordic_vec_t v, input int k);
    cordic_vec_t          r;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    xs = v.x >>> k;
    ys = v.y >>> k;
    if (!v.y[DW-1] && (v.y != '0)) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + ATAN_TURNS[k];
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - ATAN_TURNS[k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/plane_dip_and_dip_direction_top.sv
// Top level: pipelined dip and dip direction of a plane from its normal vector.
//
// Takes one plane normal per word and returns its dip and dip direction in hundredths of a
// degree. A new word can enter on every clock while output back pressure is not halting the
// pipeline. Back pressure that halts the pipeline holds each word where it is, inside the
// pipeline or parked in the input skid register. The depth is set by the one-bit-per-stage
// square root of the horizontal magnitude followed by the CORDIC vectoring chain for the dip;
// the dip direction runs its own CORDIC chain beside it and is delayed to line up. Back
// pressure on the output halts the whole pipeline at once, and the input skid register keeps
// in_tready a registered signal while one more word is still taken.
`default_nettype none

module plane_dip_and_dip_direction_top
  import pdd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // dip_angle[13:0], dip_azimuth[29:14], zero[31:30]
);

  // Pipeline advance and input skid register.
  logic             adv;
  logic             skid_vld_r;
  logic [47:0]      skid_data_r;
  logic             src_vld;
  logic [47:0]      src_data;
  logic [DEPTH-1:0] vld_r;

  assign adv       = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = !skid_vld_r;
  assign src_vld   = skid_vld_r || in_tvalid;
  assign src_data  = skid_vld_r ? skid_data_r : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (adv) begin
      skid_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_tvalid && in_tready) begin
      skid_data_r <= in_tdata;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], src_vld};
    end
  end

  // Stage 0: input register.
  logic signed [FIELD_W-1:0] nx0_r;
  logic signed [FIELD_W-1:0] ny0_r;
  logic signed [FIELD_W-1:0] nz0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx0_r <= src_data[15:0];
      ny0_r <= src_data[31:16];
      nz0_r <= src_data[47:32];
    end
  end

  // Stage 1: squares, |nz|, and the azimuth vector set into the right half plane.
  logic signed [31:0]        sqx_c;
  logic signed [31:0]        sqy_c;
  logic signed [DW-1:0]      azx_c;
  logic signed [DW-1:0]      azy_c;
  cordic_vec_t               azpre_c;
  logic [31:0]               sqx1_r;
  logic [31:0]               sqy1_r;
  logic [FIELD_W-1:0]        vz1_r;
  logic                      xyz1_r;
  cordic_vec_t               azv1_r;
  logic                      azbyp1_r;
  logic                      azneg1_r;

  assign sqx_c = nx0_r * nx0_r;
  assign sqy_c = ny0_r * ny0_r;
  assign azx_c = {{4{ny0_r[FIELD_W-1]}}, ny0_r, {GUARD_BITS{1'b0}}};
  assign azy_c = {{4{nx0_r[FIELD_W-1]}}, nx0_r, {GUARD_BITS{1'b0}}};

  always_comb begin
    if (azx_c[DW-1]) begin
      azpre_c.x = -azx_c;
      azpre_c.y = -azy_c;
      azpre_c.z = HALF_TURN;
    end else begin
      azpre_c.x = azx_c;
      azpre_c.y = azy_c;
      azpre_c.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx1_r   <= sqx_c;
      sqy1_r   <= sqy_c;
      vz1_r    <= nz0_r[FIELD_W-1] ? FIELD_W'(~nz0_r + 1'b1) : nz0_r;
      xyz1_r   <= (nx0_r == '0) && (ny0_r == '0);
      azv1_r   <= azpre_c;
      azbyp1_r <= (nx0_r == '0);
      azneg1_r <= ny0_r[FIELD_W-1];
    end
  end

  // Stage 2: sum of squares.
  logic [31:0]        s2_r;
  logic [FIELD_W-1:0] vz2_r;
  logic               xyz2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r   <= sqx1_r + sqy1_r;
      vz2_r  <= vz1_r;
      xyz2_r <= xyz1_r;
    end
  end

  // Square root of (sum << 32), one result bit per stage.
  logic [REM_W-1:0]   rem_r   [SQRT_STEPS];
  logic [ROOT_W-1:0]  root_r  [SQRT_STEPS];
  logic [31:0]        sq_r    [SQRT_STEPS];
  logic [FIELD_W-1:0] sqvz_r  [SQRT_STEPS];
  logic               sqxyz_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [31:0]        sq_in;
    logic [FIELD_W-1:0] vz_in;
    logic               xyz_in;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = s2_r;
      assign vz_in   = vz2_r;
      assign xyz_in  = xyz2_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign sq_in   = sq_r[j-1];
      assign vz_in   = sqvz_r[j-1];
      assign xyz_in  = sqxyz_r[j-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], sq_in[31:30]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          rem_r[j]  <= rem_sh - trial;
          root_r[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= rem_sh;
          root_r[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        sq_r[j]    <= {sq_in[29:0], 2'b00};
        sqvz_r[j]  <= vz_in;
        sqxyz_r[j] <= xyz_in;
      end
    end
  end

  // Dip CORDIC: vector (|nz|, horizontal magnitude), both at the same scale.
  cordic_vec_t dcv_r  [CORDIC_N];
  logic        dxyz_r [CORDIC_N];

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_dip
    cordic_vec_t v_in;
    logic        xyz_in;

    if (k == 0) begin : g_first
      assign v_in   = {{4'b0000, sqvz_r[SQRT_STEPS-1], {GUARD_BITS{1'b0}}},
                       {4'b0000, root_r[SQRT_STEPS-1], 8'h00},
                       {ANGLE_W{1'b0}}};
      assign xyz_in = sqxyz_r[SQRT_STEPS-1];
    end else begin : g_next
      assign v_in   = dcv_r[k-1];
      assign xyz_in = dxyz_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dcv_r[k]  <= cordic_step(v_in, k);
        dxyz_r[k] <= xyz_in;
      end
    end
  end

  // Azimuth CORDIC: vector (ny, nx).
  cordic_vec_t acv_r  [CORDIC_N];
  logic        abyp_r [CORDIC_N];
  logic        aneg_r [CORDIC_N];

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_az
    cordic_vec_t v_in;
    logic        byp_in;
    logic        neg_in;

    if (k == 0) begin : g_first
      assign v_in   = azv1_r;
      assign byp_in = azbyp1_r;
      assign neg_in = azneg1_r;
    end else begin : g_next
      assign v_in   = acv_r[k-1];
      assign byp_in = abyp_r[k-1];
      assign neg_in = aneg_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        acv_r[k]  <= cordic_step(v_in, k);
        abyp_r[k] <= byp_in;
        aneg_r[k] <= neg_in;
      end
    end
  end

  // Azimuth scaling to hundredths of a degree, then rounding, wrap and the zero-east case.
  logic [47:0] az_prod_r;
  logic        az_byp_m_r;
  logic        az_neg_m_r;
  logic [47:0] az_sum_c;
  logic [15:0] az_rnd_c;
  logic [15:0] az_fin_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      az_prod_r  <= 48'(acv_r[CORDIC_N-1].z) * 48'(TURN_CDEG);
      az_byp_m_r <= abyp_r[CORDIC_N-1];
      az_neg_m_r <= aneg_r[CORDIC_N-1];
    end
  end

  assign az_sum_c = az_prod_r + 48'h00_0080_0000_00;
  assign az_rnd_c = az_sum_c[47:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (az_byp_m_r) begin
        az_fin_r <= az_neg_m_r ? HALF_CDEG : '0;
      end else if (az_rnd_c >= TURN_CDEG) begin
        az_fin_r <= '0;
      end else begin
        az_fin_r <= az_rnd_c;
      end
    end
  end

  // Delay line that lines the azimuth up with the longer dip path.
  logic [15:0] az_dly_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_az_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        az_dly_r[j] <= (j == 0) ? az_fin_r : az_dly_r[(j == 0) ? 0 : j-1];
      end
    end
  end

  // Dip scaling; a vertical normal or a non-positive angle gives zero dip.
  logic [ANGLE_W-1:0] dip_z_c;
  logic [46:0]        dip_prod_r;
  logic               dip_zero_r;
  logic [46:0]        dip_sum_c;
  logic [14:0]        dip_rnd_c;
  logic [13:0]        dip_out_r;
  logic [15:0]        az_out_r;

  assign dip_z_c = dcv_r[CORDIC_N-1].z;

  always_ff @(posedge clk) begin
    if (adv) begin
      dip_prod_r <= 47'(dip_z_c[ANGLE_W-2:0]) * 47'(TURN_CDEG);
      dip_zero_r <= dxyz_r[CORDIC_N-1] || dip_z_c[ANGLE_W-1] || (dip_z_c == '0);
    end
  end

  assign dip_sum_c = dip_prod_r + 47'h0000_8000_0000;
  assign dip_rnd_c = dip_sum_c[46:32];

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (dip_zero_r) begin
        dip_out_r <= '0;
      end else if (dip_rnd_c > 15'(DIP_MAX)) begin
        dip_out_r <= DIP_MAX;
      end else begin
        dip_out_r <= dip_rnd_c[13:0];
      end
      az_out_r <= az_dly_r[SQRT_STEPS-1];
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = {2'b00, az_out_r, dip_out_r};

  // The dip never leaves its range.
  a_dip_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[13:0] <= DIP_MAX))
    else $error("dip_angle above 90 degrees");

  // The azimuth is always folded below a full turn.
  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:14] < TURN_CDEG))
    else $error("dip_azimuth not below 360 degrees");

  // A word taken during a stall is parked in the skid register.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !adv) |=> skid_vld_r)
    else $error("stalled input word was not parked");

  // A parked word moves into the pipeline on the next advance.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && adv) |=> (!skid_vld_r && vld_r[0]))
    else $error("parked input word was not forwarded");

endmodule

`default_nettype wire

FILE: test/tb_plane_dip_and_dip_direction_top.sv
// Self-checking testbench for the plane dip and dip direction pipeline.
`timescale 1ns / 100ps

module tb_plane_dip_and_dip_direction_top;

  // Run shape.
  localparam int RANDOM_NORMALS = 1700;
  localparam int HOLD_AT_RESULT = 820;
  localparam int LONG_HOLD      = 300;
  localparam int QUIET_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int PRINT_LIMIT    = 50;

  // Predictor constants: angles in 2^-32 turn units, results in hundredths of a degree.
  localparam int ROTATIONS = (pdd_pkg::CORDIC_STAGES < 24) ? pdd_pkg::CORDIC_STAGES : 24;
  localparam longint GUARD_SCALE = 64'sd1 <<< 24;
  localparam longint unsigned ROUND_HALF = 64'h8000_0000;
  localparam bit [31:0] HALF_TURN_ANGLE = 32'h8000_0000;
  localparam logic [15:0] FULL_CIRCLE_CDEG = 16'd36000;
  localparam logic [15:0] SOUTH_CDEG = 16'd18000;
  localparam logic [13:0] DIP_LIMIT = 14'd9000;
  localparam bit [31:0] ARCTAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum int {COMP_FULL, COMP_SMALL, COMP_EXTREME} comp_kind_t;

  // One normal waiting to be sent, with the idle time in front of it.
  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    int                 gap_before;
    bit                 drain_first;
  } normal_item_t;

  // Expected attitude, kept with its normal for messages.
  typedef struct {
    logic [13:0]        dip;
    logic [15:0]        azim;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } attitude_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // dip_angle[13:0], dip_azimuth[29:14], zero[31:30]

  normal_item_t pending_q[$];
  attitude_t    attitude_q[$];
  normal_item_t cur_normal;

  int mismatch_count     = 0;
  int normals_taken      = 0;
  int results_seen       = 0;
  int zero_east_count    = 0;
  int vertical_count     = 0;
  int input_stall_cycles = 0;
  int stall_left         = 0;
  int stall_pick         = 0;
  int quiet_cycles       = 0;
  bit long_hold_done     = 1'b0;

  plane_dip_and_dip_direction_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock and a single reset pulse.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] pick_component(comp_kind_t kind);
    logic signed [15:0] c;
    case (kind)
      COMP_SMALL: c = 16'($urandom_range(0, 16) - 8);
      COMP_EXTREME: begin
        case ($urandom_range(0, 5))
          0: c = -16'sd32768;
          1: c = -16'sd32767;
          2: c = -16'sd1;
          3: c = 16'sd0;
          4: c = 16'sd1;
          default: c = 16'sd32767;
        endcase
      end
      default: c = 16'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  // CORDIC vectoring of (x, y); the angle wraps modulo one turn.
  function automatic bit [31:0] vector_angle(longint x, longint y);
    bit [31:0] z;
    longint    xs;
    longint    ys;
    int        i;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN_ANGLE;
    end
    for (i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_TURNS[i];
      end
    end
    return z;
  endfunction

  // Dip and dip direction of one normal.
  function automatic attitude_t predict_attitude(input logic signed [15:0] nx,
                                                 input logic signed [15:0] ny,
                                                 input logic signed [15:0] nz);
    attitude_t       res;
    longint          east;
    longint          north;
    longint          up;
    longint          horiz;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    longint unsigned scaled;
    bit [31:0]       ang;
    east  = nx;
    north = ny;
    up    = nz;
    res.nx = nx;
    res.ny = ny;
    res.nz = nz;

    // Dip direction: a zero east component points straight north or south.
    if (east == 0) begin
      res.azim = (north >= 0) ? 16'd0 : SOUTH_CDEG;
    end else begin
      ang = vector_angle(north * GUARD_SCALE, east * GUARD_SCALE);
      scaled = ang;
      scaled = (scaled * 36000 + ROUND_HALF) >> 32;
      res.azim = (scaled >= FULL_CIRCLE_CDEG) ? 16'd0 : scaled[15:0];
    end

    // Dip: zero for a vertical normal, clamped to the 0 to 90 degree range.
    res.dip = '0;
    if (east != 0 || north != 0) begin
      rem  = east * east + north * north;
      rem  = rem << 32;
      root = 0;
      b    = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem  = rem - root - b;
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      horiz = root * 256;
      ang = vector_angle(((up < 0) ? -up : up) * GUARD_SCALE, horiz);
      if ($signed(ang) > 0) begin
        scaled = ang;
        scaled = (scaled * 36000 + ROUND_HALF) >> 32;
        res.dip = (scaled > DIP_LIMIT) ? DIP_LIMIT : scaled[13:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, attitude_t want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] result %0d (normal %0d,%0d,%0d): %s got %0d, want %0d", $time,
               results_seen, want.nx, want.ny, want.nz, field, got,
               (field == "dip_angle") ? int'(want.dip) : int'(want.azim));
  endtask

  task automatic add_normal(int nx, int ny, int nz, int gap, bit drain);
    normal_item_t it;
    it.nx = 16'(nx);
    it.ny = 16'(ny);
    it.nz = 16'(nz);
    it.gap_before = gap;
    it.drain_first = drain;
    pending_q.insert(pending_q.size(), it);
  endtask

  // Sender: one word from the pending queue, honoring gaps and drain points.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && !in_tready) input_stall_cycles++;
      if (in_tvalid && in_tready) begin
        attitude_q.insert(attitude_q.size(),
                          predict_attitude(cur_normal.nx, cur_normal.ny, cur_normal.nz));
        normals_taken++;
        if (cur_normal.nx == 0) zero_east_count++;
        if (cur_normal.nx == 0 && cur_normal.ny == 0) vertical_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_q[0].drain_first && attitude_q.size() != 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_q[0].gap_before > 0) begin
          pending_q[0].gap_before = pending_q[0].gap_before - 1;
          in_tvalid <= 1'b0;
        end else begin
          cur_normal = pending_q.pop_front();
          in_tdata  <= {cur_normal.nz, cur_normal.ny, cur_normal.nx};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Receiver: check each word against the oldest expected attitude, then pick the stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (attitude_q.size() == 0) begin
          report_mismatch("word with no normal pending", out_tdata, '{default: '0});
        end else begin
          if (out_tdata[13:0] != attitude_q[0].dip)
            report_mismatch("dip_angle", int'(out_tdata[13:0]), attitude_q[0]);
          if (out_tdata[29:14] != attitude_q[0].azim)
            report_mismatch("dip_azimuth", int'(out_tdata[29:14]), attitude_q[0]);
          void'(attitude_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AT_RESULT) begin
        // Long hold so the pipeline fills and the input stalls.
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if ((results_seen / 250) % 3 == 1) begin
        out_tready <= 1'b1;
      end else begin
        stall_pick = pick_idle();
        out_tready <= (stall_pick == 0);
        if (stall_pick > 0) stall_left = stall_pick - 1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    normal_item_t it;
    int           i;
    int           cls;

    // Directed normals: axes, extremes, wrap to north, dip clamps.
    add_normal(0, 0, 32767, 0, 1'b0);
    add_normal(0, 0, -32768, 0, 1'b0);
    add_normal(0, 0, 0, 0, 1'b0);
    add_normal(0, 32767, 0, 0, 1'b0);
    add_normal(0, -32768, 0, 0, 1'b0);
    add_normal(0, -1, 5, 0, 1'b0);
    add_normal(32767, 0, 0, 0, 1'b0);
    add_normal(-32768, 0, 0, 0, 1'b0);
    add_normal(-1, 32767, 0, 0, 1'b0);
    add_normal(-1, 32767, -32768, 0, 1'b0);
    add_normal(1, 32767, 100, 0, 1'b0);
    add_normal(1, 0, -32768, 0, 1'b0);
    add_normal(-1, 0, 32767, 0, 1'b0);
    add_normal(0, 1, 32767, 0, 1'b0);
    add_normal(32767, 32767, 1, 0, 1'b0);
    add_normal(-32768, -32768, -32768, 0, 1'b0);
    add_normal(-32768, 32767, 32767, 0, 1'b0);
    add_normal(32767, -32768, 0, 0, 1'b0);
    add_normal(1, 1, 0, 0, 1'b0);
    add_normal(-1, -1, -1, 0, 1'b0);
    add_normal(16'h5555, 16'h2AAA, 16'h5555, 0, 1'b0);
    add_normal(-21846, 21845, -21846, 0, 1'b0);
    add_normal(1234, -4321, 777, 0, 1'b0);

    // Random normals in several flavors; some stretches run with no gaps at all.
    for (i = 0; i < RANDOM_NORMALS; i++) begin
      it.nx = pick_component(COMP_FULL);
      it.ny = pick_component(COMP_FULL);
      it.nz = pick_component(COMP_FULL);
      cls = $urandom_range(0, 9);
      case (cls)
        4: it.nx = 0;
        5: begin
          it.ny = 0;
          it.nx = pick_component(($urandom_range(0, 1) == 0) ? COMP_SMALL : COMP_FULL);
        end
        6: begin
          it.nx = pick_component(COMP_SMALL);
          it.ny = pick_component(COMP_SMALL);
          it.nz = pick_component(COMP_SMALL);
        end
        7: it.nz = pick_component(COMP_SMALL);
        8: begin
          it.nx = pick_component(COMP_EXTREME);
          it.ny = pick_component(COMP_EXTREME);
          it.nz = pick_component(COMP_EXTREME);
        end
        9: begin
          it.nx = pick_component(COMP_SMALL);
          it.ny = pick_component(COMP_EXTREME);
        end
        default: ;
      endcase
      it.gap_before = ((i / 200) % 4 == 0) ? 0 : pick_idle();
      it.drain_first = (i == 0) || (i == 1300);
      pending_q.insert(pending_q.size(), it);
    end

    while (pending_q.size() != 0 || in_tvalid || attitude_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (attitude_q.size() != 0) report_mismatch("dip_angle", -1, attitude_q[0]);

    $display("Checked %0d dip/direction words from %0d normals (%0d with zero east, %0d vertical).",
             results_seen, normals_taken, zero_east_count, vertical_count);
    $display("Input held off for %0d cycles under output back pressure.", input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/pdd_pkg.sv
sv/plane_dip_and_dip_direction_top.sv
test/tb_plane_dip_and_dip_direction_top.sv
